### src/gbn_sw_pkg.sv
// Shared constants, codes and control types of the go-back-N sender window unit.
`timescale 1ns / 1ps
`default_nettype none

package gbn_sw_pkg;

  // Sequence numbers and window limits.
  localparam int SEQ_BITS    = 16;
  localparam int MAX_WINDOW  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int BURST_CAP   = (MAX_WINDOW < MAX_RESULTS) ? MAX_WINDOW : MAX_RESULTS;
  localparam int SUM_BITS    = SEQ_BITS + 1;

  typedef logic [SEQ_BITS-1:0] seq_t;

  // Largest burst, in the width of the window size register.
  localparam logic [4:0] BURST_CAP_W = 5'(BURST_CAP);

  // Event codes.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SEND     = 2'd0;
  localparam logic [1:0] KIND_RETX     = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_GIVEUP   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_TOTAL_PACKETS = 2'd1;
  localparam logic [1:0] REG_MAX_TRIES     = 2'd2;
  localparam logic [1:0] REG_DUP_THRESHOLD = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic plan;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_results;
    logic last_item;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### src/gbn_sw_ifs.sv
// Valid/ready channel interfaces for the event and result items.
`timescale 1ns / 1ps
`default_nettype none

interface gbn_sw_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] ack_cumulative;

  modport source (output valid, output operation, output ack_cumulative, input ready);
  modport sink (input valid, input operation, input ack_cumulative, output ready);
endinterface

interface gbn_sw_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seq_number;
  logic        last;

  modport source (output valid, output kind, output seq_number, output last, input ready);
  modport sink (input valid, input kind, input seq_number, input last, output ready);
endinterface

`default_nettype wire

### src/gbn_sw_dpath.sv
// Datapath: window state, configuration, event evaluation, burst counter and output register.
`timescale 1ns / 1ps
`default_nettype none

module gbn_sw_dpath
  import gbn_sw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          st,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] ack_cumulative,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_seq,
  output logic             out_last
);

  // Outcome of evaluating one event.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_GIVEUP,
    ACT_DONE,
    ACT_RETX,
    ACT_BURST,
    ACT_SLIDE
  } act_t;

  // Configuration registers.
  logic [4:0] window_size;
  seq_t       total_packets;
  logic [3:0] max_tries;
  logic [2:0] dup_threshold;

  // Window state.
  seq_t       window_base;
  seq_t       next_to_send;
  logic [2:0] duplicate_count;
  logic [3:0] timeout_count;

  // Event being worked on and its plan.
  logic [1:0]          op_q;
  seq_t                ack_q;
  act_t                act;
  logic [1:0]          burst_kind;
  logic [SUM_BITS-1:0] sum;
  seq_t                cur;
  seq_t                stop;
  logic [1:0]          emit_kind;

  logic [4:0] w_eff;
  seq_t       sum_base;
  seq_t       end_c;
  seq_t       first_c;
  seq_t       cur_inc;
  logic       has_c;

  // Burst width, capped at BURST_CAP, and the base from which the raw window end is reckoned.
  assign w_eff    = (window_size > BURST_CAP_W) ? BURST_CAP_W : window_size;
  assign sum_base = (op_q == OP_ACK) ? ack_q : window_base;

  // Window end clipped to the transfer, and the first number of the burst.
  assign end_c   = (sum > {1'b0, total_packets}) ? total_packets : sum[SEQ_BITS-1:0];
  assign first_c = (act == ACT_SLIDE && next_to_send > window_base) ? next_to_send
                                                                    : window_base;
  assign cur_inc = cur + seq_t'(1);

  // Whether the planned event yields any item.
  always_comb begin
    case (act)
      ACT_GIVEUP, ACT_DONE, ACT_RETX: has_c = 1'b1;
      ACT_BURST, ACT_SLIDE:           has_c = (first_c < end_c);
      default:                        has_c = 1'b0;
    endcase
  end

  assign st.has_results = has_c;
  assign st.last_item   = (cur_inc == stop);
  assign st.out_free    = !out_valid || out_ready;

  // Configuration, event latch, evaluation and planning.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= 5'd5;
      total_packets   <= seq_t'(24);
      max_tries       <= 4'd5;
      dup_threshold   <= 3'd3;
      window_base     <= '0;
      next_to_send    <= '0;
      duplicate_count <= '0;
      timeout_count   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE:   window_size   <= cfg_data[4:0];
          REG_TOTAL_PACKETS: total_packets <= cfg_data;
          REG_MAX_TRIES:     max_tries     <= cfg_data[3:0];
          REG_DUP_THRESHOLD: dup_threshold <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        op_q  <= operation;
        ack_q <= ack_cumulative;
      end

      // Classify the event against the old state and apply the simple updates.
      if (cmd.eval) begin
        sum        <= {1'b0, sum_base} + SUM_BITS'(w_eff);
        burst_kind <= (op_q == OP_TIMEOUT) ? KIND_RETX : KIND_SEND;
        case (op_q)
          OP_START: begin
            act <= (window_base >= total_packets) ? ACT_DONE : ACT_BURST;
          end
          OP_TIMEOUT: begin
            if (timeout_count >= max_tries) begin
              act <= ACT_GIVEUP;
            end else begin
              timeout_count <= timeout_count + 4'd1;
              act <= (window_base >= total_packets) ? ACT_DONE : ACT_BURST;
            end
          end
          OP_ACK: begin
            if (ack_q == total_packets) begin
              window_base     <= ack_q;
              duplicate_count <= '0;
              if (next_to_send < ack_q) begin
                next_to_send <= ack_q;
              end
              act <= ACT_DONE;
            end else if (ack_q > total_packets || ack_q < window_base) begin
              act <= ACT_NONE;
            end else if (ack_q == window_base) begin
              if (duplicate_count != 3'd7) begin
                duplicate_count <= duplicate_count + 3'd1;
                act <= (duplicate_count + 3'd1 == dup_threshold) ? ACT_RETX : ACT_NONE;
              end else begin
                act <= ACT_NONE;
              end
            end else begin
              window_base     <= ack_q;
              duplicate_count <= '0;
              act             <= ACT_SLIDE;
            end
          end
          default: act <= ACT_NONE;
        endcase
      end

      // Set up the run of items and move the send pointer.
      if (cmd.plan) begin
        case (act)
          ACT_GIVEUP: begin
            cur       <= '0;
            stop      <= seq_t'(1);
            emit_kind <= KIND_GIVEUP;
          end
          ACT_DONE: begin
            cur       <= '0;
            stop      <= seq_t'(1);
            emit_kind <= KIND_COMPLETE;
          end
          ACT_RETX: begin
            cur       <= ack_q;
            stop      <= ack_q + seq_t'(1);
            emit_kind <= KIND_RETX;
          end
          ACT_BURST: begin
            cur          <= window_base;
            stop         <= end_c;
            emit_kind    <= burst_kind;
            next_to_send <= end_c;
          end
          ACT_SLIDE: begin
            cur       <= first_c;
            stop      <= end_c;
            emit_kind <= KIND_SEND;
            if (end_c > next_to_send) begin
              next_to_send <= end_c;
            end
          end
          default: ;
        endcase
      end

      if (cmd.emit) begin
        cur <= cur_inc;
      end
    end
  end

  // Output register: holds one item until the result side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      out_kind  <= emit_kind;
      out_seq   <= cur;
      out_last  <= st.last_item;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // An item is only loaded into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("item loaded over an untaken item");

  // The send pointer never trails the window base between events.
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (next_to_send >= window_base))
    else $error("send pointer below window base");

  // Every emitted number lies inside the planned run.
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (cur < stop))
    else $error("burst counter ran past its end");

  // A run has no gap: a taken item without the last mark is followed at once.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a run of items");

endmodule

`default_nettype wire

### src/gbn_sw_ctrl.sv
// Controller: state machine that steps each event through evaluation, planning and emission.
`timescale 1ns / 1ps
`default_nettype none

module gbn_sw_ctrl
  import gbn_sw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_PLAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow from the state, with the input handshake and the room in the output register.
  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_ready && in_valid;
  assign cmd.eval = (state == S_EVAL);
  assign cmd.plan = (state == S_PLAN);
  assign cmd.emit = (state == S_EMIT) && st.out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: state_next = S_PLAN;
      S_PLAN: begin
        state_next = st.has_results ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free && st.last_item) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/go_back_n_sender_window_unit.sv
// Top level of the go-back-N sender window unit.
//
// Each accepted event (start, cumulative ack, timeout) is evaluated against the window
// state in the evaluation state and planned in the plan state, then its result items leave
// one per cycle through an output register while the result side keeps taking them (a
// burst has at most 16 sends); an event with no result returns the unit to idle from the
// plan state. The controller takes a new event only when idle, and the burst counter that
// walks the window sets the rate of the sends. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the unit is idle, as
// the unit itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window_unit
  import gbn_sw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  gbn_sw_event_if.sink     events,
  gbn_sw_result_if.source  results,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  // Sequencing of each event.
  gbn_sw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign events.ready = in_ready;

  // Window state and result generation.
  gbn_sw_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .operation      (events.operation),
    .ack_cumulative (events.ack_cumulative),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_kind       (results.kind),
    .out_seq        (results.seq_number),
    .out_last       (results.last)
  );

endmodule

`default_nettype wire
